@@ rtl/rttt_pkg.sv @@
`default_nettype none

package rttt_pkg;

    // Default geometry
    localparam int DEF_HISTORY_DEPTH     = 6;
    localparam int DEF_MIN_TREND_HISTORY = 4;
    localparam int DEF_HOLD_COUNT        = 3;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam int RSSI_W = 8;
    localparam int TIME_W = 32;
    localparam int LVL_W  = 3;
    localparam int MOVE_W = 2;
    localparam int IDX_W  = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_THREAT_LOW      = 3'd0;
    localparam logic [IDX_W-1:0] REG_THREAT_MEDIUM   = 3'd1;
    localparam logic [IDX_W-1:0] REG_THREAT_HIGH     = 3'd2;
    localparam logic [IDX_W-1:0] REG_THREAT_CRITICAL = 3'd3;
    localparam logic [IDX_W-1:0] REG_APPROACH_MARGIN = 3'd4;
    localparam logic [IDX_W-1:0] REG_RECEDE_MARGIN   = 3'd5;
    localparam logic [IDX_W-1:0] REG_SILENCE_LEVEL   = 3'd6;
    localparam logic [IDX_W-1:0] REG_INITIAL_RSSI    = 3'd7;

    // Threat levels
    localparam logic [LVL_W-1:0] LVL_NONE     = 3'd0;
    localparam logic [LVL_W-1:0] LVL_LOW      = 3'd1;
    localparam logic [LVL_W-1:0] LVL_MEDIUM   = 3'd2;
    localparam logic [LVL_W-1:0] LVL_HIGH     = 3'd3;
    localparam logic [LVL_W-1:0] LVL_CRITICAL = 3'd4;

    typedef enum logic [MOVE_W-1:0] {
        TR_UNKNOWN     = 2'd0,
        TR_APPROACHING = 2'd1,
        TR_STATIC      = 2'd2,
        TR_RECEDING    = 2'd3
    } t_trend;

    typedef struct packed {
        logic signed [RSSI_W-1:0] threat_low;
        logic signed [RSSI_W-1:0] threat_medium;
        logic signed [RSSI_W-1:0] threat_high;
        logic signed [RSSI_W-1:0] threat_critical;
        logic signed [RSSI_W-1:0] approach_margin;
        logic signed [RSSI_W-1:0] recede_margin;
        logic signed [RSSI_W-1:0] silence_level;
        logic signed [RSSI_W-1:0] initial_rssi;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        threat_low:      -8'sd90,
        threat_medium:   -8'sd80,
        threat_high:     -8'sd70,
        threat_critical: -8'sd60,
        approach_margin:  8'sd3,
        recede_margin:   -8'sd3,
        silence_level:   -8'sd110,
        initial_rssi:    -8'sd120
    };

    // One queued request: sample plus the rise decision made up front
    typedef struct packed {
        logic signed [RSSI_W-1:0] sample;
        logic                     rose;
        logic [TIME_W-1:0]        rise_time;
    } t_qent;

endpackage

`default_nettype wire

@@ rtl/rttt_front.sv @@
`default_nettype none

module rttt_front
    import rttt_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cfg                     i_cfg,
    input  wire logic                     i_valid,
    input  wire logic signed [RSSI_W-1:0] i_rssi_sample,
    input  wire logic [TIME_W-1:0]        i_sample_time,
    input  wire logic                     i_q_full,
    output logic                          o_push,
    output t_qent                         o_ent
);

    logic                     r_seen;
    logic signed [RSSI_W-1:0] r_prev;
    logic [TIME_W-1:0]        r_rise_time;

    logic signed [RSSI_W-1:0] prev;
    logic                     rose;

    // before the first sample the noise floor register stands in
    assign prev   = r_seen ? r_prev : $signed(i_cfg.initial_rssi);
    assign rose   = i_rssi_sample > prev;
    assign o_push = i_valid && !i_q_full;

    always_comb begin
        o_ent.sample    = i_rssi_sample;
        o_ent.rose      = rose;
        o_ent.rise_time = rose ? i_sample_time : r_rise_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_rise_time <= '0;
        end else if (o_push) begin
            r_seen <= 1'b1;
            if (rose) begin
                r_rise_time <= i_sample_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_prev <= i_rssi_sample;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rttt_fifo.sv @@
`default_nettype none

module rttt_fifo
    import rttt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_ent,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_nonempty,
    output t_qent      o_ent
);

    t_qent            r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_count;

    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == QCW'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;
    assign o_ent      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rttt_div.sv @@
`default_nettype none

// Signed by unsigned divide, truncating toward zero; one quotient bit a cycle.
module rttt_div #(
    parameter int NW = 11,
    parameter int DW = 3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [NW-1:0] i_dividend,
    input  wire logic [DW-1:0]        i_divisor,
    output logic                      o_done,
    output logic signed [NW-1:0]      o_quot
);

    localparam int CNW = $clog2(NW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNW-1:0]    r_cnt;
    logic [NW-1:0]     r_mag;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_div;
    logic              r_neg;

    logic [DW:0]       rem_sh;
    logic              ge;
    logic [DW:0]       rem_nx;

    assign rem_sh = {r_rem, r_mag[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign rem_nx = ge ? (rem_sh - {1'b0, r_div}) : rem_sh;
    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(-r_mag) : $signed(r_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_dividend[NW-1] ? NW'(-i_dividend) : i_dividend;
            r_neg <= i_dividend[NW-1];
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[NW-2:0], ge};
            r_rem <= rem_nx[DW-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/rttt_back.sv @@
`default_nettype none

module rttt_back
    import rttt_pkg::*;
#(
    parameter int HISTORY_DEPTH     = DEF_HISTORY_DEPTH,
    parameter int MIN_TREND_HISTORY = DEF_MIN_TREND_HISTORY,
    parameter int HOLD_COUNT        = DEF_HOLD_COUNT,
    parameter int CW                = $clog2(HISTORY_DEPTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cfg                     i_cfg,
    input  wire logic                     i_q_nonempty,
    input  wire t_qent                    i_q_ent,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [LVL_W-1:0]              o_threat_level,
    output logic [MOVE_W-1:0]             o_movement,
    output logic signed [RSSI_W-1:0]      o_average_rssi,
    output logic                          o_rose,
    output logic [TIME_W-1:0]             o_last_rise_time,
    output logic [CW-1:0]                 o_valid_count
);

    localparam int AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SW   = RSSI_W + CW;
    localparam int HCW  = $clog2(HOLD_COUNT + 1);
    localparam logic [AW-1:0] HALF  = AW'(HISTORY_DEPTH / 2);
    localparam logic [AW-1:0] LAST  = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH = CW'(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        D_AVG,
        D_NEW,
        D_OLD
    } t_dsel;

    t_state                   r_state;
    t_dsel                    r_dsel;
    logic                     r_dgo;
    logic                     n_dgo;

    logic signed [RSSI_W-1:0] r_hist [HISTORY_DEPTH];
    logic [AW-1:0]            r_wp;
    logic [CW-1:0]            r_fill;
    logic [AW-1:0]            r_addr;
    logic [AW-1:0]            r_pos;

    logic signed [RSSI_W-1:0] r_peak;
    logic signed [SW-1:0]     r_sum;
    logic signed [SW-1:0]     r_old_sum;
    logic signed [SW-1:0]     r_new_sum;
    logic [CW-1:0]            r_old_n;
    logic [CW-1:0]            r_new_n;
    logic signed [RSSI_W-1:0] r_avg;
    logic signed [RSSI_W-1:0] r_new_avg;
    logic signed [RSSI_W-1:0] r_old_avg;
    logic                     r_rose;
    logic [TIME_W-1:0]        r_rise_time;

    t_trend                   r_held;
    logic [HCW-1:0]           r_hold;

    logic                     r_ovalid;
    logic [LVL_W-1:0]         r_olevel;
    t_trend                   r_omove;
    logic signed [RSSI_W-1:0] r_oavg;
    logic                     r_orose;
    logic [TIME_W-1:0]        r_orise;
    logic [CW-1:0]            r_ocount;

    // walk / divide helpers
    logic signed [RSSI_W-1:0] v;
    logic signed [SW-1:0]     v_ext;
    logic                     loud;
    logic [CW-1:0]            fill_nx;
    logic [AW-1:0]            wp_nx;
    logic                     walk_end;
    logic                     trend_ok;
    logic signed [SW-1:0]     div_a;
    logic [CW-1:0]            div_b;
    logic                     div_done;
    logic signed [SW-1:0]     div_q;

    // result helpers
    logic signed [RSSI_W:0]   diff;
    t_trend                   raw;
    t_trend                   move;
    t_trend                   held_nx;
    logic [HCW-1:0]           hold_nx;
    logic [HCW-1:0]           hold_inc;
    logic [LVL_W-1:0]         level;
    logic                     out_free;
    logic                     load_out;

    assign v        = r_hist[r_addr];
    assign v_ext    = {{CW{v[RSSI_W-1]}}, v};
    assign loud     = v > $signed(i_cfg.silence_level);
    assign fill_nx  = (r_fill < DEPTH) ? r_fill + 1'b1 : r_fill;
    assign wp_nx    = (r_wp == LAST) ? '0 : r_wp + 1'b1;
    assign walk_end = (CW'(r_pos) == r_fill - CW'(1));
    assign trend_ok = (32'(r_fill) >= 32'(MIN_TREND_HISTORY))
                      && (r_old_n != '0) && (r_new_n != '0);
    assign out_free = !r_ovalid || !i_stall;
    assign load_out = (r_state == S_DONE) && out_free;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_nonempty;

    // divider kick: after the walk, then for each trend mean
    assign n_dgo = ((r_state == S_WALK) && walk_end)
                   || ((r_state == S_DIV) && div_done
                       && ((r_dsel == D_NEW) || ((r_dsel == D_AVG) && trend_ok)));

    always_comb begin
        unique case (r_dsel)
            D_AVG: begin
                div_a = r_sum;
                div_b = r_fill;
            end
            D_NEW: begin
                div_a = r_new_sum;
                div_b = r_new_n;
            end
            D_OLD: begin
                div_a = r_old_sum;
                div_b = r_old_n;
            end
            default: begin
                div_a = r_sum;
                div_b = r_fill;
            end
        endcase
    end

    rttt_div #(
        .NW (SW),
        .DW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dgo),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // threat level from the history peak
    always_comb begin
        priority if (r_peak >= $signed(i_cfg.threat_critical)) begin
            level = LVL_CRITICAL;
        end else if (r_peak >= $signed(i_cfg.threat_high)) begin
            level = LVL_HIGH;
        end else if (r_peak >= $signed(i_cfg.threat_medium)) begin
            level = LVL_MEDIUM;
        end else if (r_peak >= $signed(i_cfg.threat_low)) begin
            level = LVL_LOW;
        end else begin
            level = LVL_NONE;
        end
    end

    // raw trend, then hold-count hysteresis
    always_comb begin
        diff = {r_new_avg[RSSI_W-1], r_new_avg} - {r_old_avg[RSSI_W-1], r_old_avg};
        if (!trend_ok) begin
            raw = TR_UNKNOWN;
        end else if (diff > $signed({i_cfg.approach_margin[RSSI_W-1],
                                     i_cfg.approach_margin})) begin
            raw = TR_APPROACHING;
        end else if (diff < $signed({i_cfg.recede_margin[RSSI_W-1],
                                     i_cfg.recede_margin})) begin
            raw = TR_RECEDING;
        end else begin
            raw = TR_STATIC;
        end

        hold_inc = r_hold + 1'b1;
        held_nx  = r_held;
        hold_nx  = r_hold;
        move     = r_held;
        priority if (raw == r_held) begin
            hold_nx = '0;
        end else if (raw == TR_UNKNOWN) begin
            move = r_held;
        end else if (r_held == TR_UNKNOWN) begin
            hold_nx = '0;
            held_nx = raw;
            move    = raw;
        end else if (r_hold < HCW'(HOLD_COUNT)) begin
            if (hold_inc < HCW'(HOLD_COUNT)) begin
                hold_nx = hold_inc;
            end else begin
                hold_nx = '0;
                held_nx = raw;
                move    = raw;
            end
        end else begin
            hold_nx = '0;
            held_nx = raw;
            move    = raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dsel   <= D_AVG;
            r_dgo    <= 1'b0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_held   <= TR_UNKNOWN;
            r_hold   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_dgo <= n_dgo;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_nonempty) begin
                        r_hist[r_wp] <= i_q_ent.sample;
                        r_wp         <= wp_nx;
                        r_fill       <= fill_nx;
                        // full ring reads oldest first from the write pointer
                        r_addr       <= (fill_nx == DEPTH) ? wp_nx : '0;
                        r_pos        <= '0;
                        r_peak       <= {1'b1, {(RSSI_W-1){1'b0}}};
                        r_sum        <= '0;
                        r_old_sum    <= '0;
                        r_new_sum    <= '0;
                        r_old_n      <= '0;
                        r_new_n      <= '0;
                        r_rose       <= i_q_ent.rose;
                        r_rise_time  <= i_q_ent.rise_time;
                        r_state      <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (v > r_peak) begin
                        r_peak <= v;
                    end
                    r_sum <= r_sum + v_ext;
                    if (loud) begin
                        if (r_pos < HALF) begin
                            r_old_sum <= r_old_sum + v_ext;
                            r_old_n   <= r_old_n + 1'b1;
                        end else begin
                            r_new_sum <= r_new_sum + v_ext;
                            r_new_n   <= r_new_n + 1'b1;
                        end
                    end
                    r_addr <= (r_addr == LAST) ? '0 : r_addr + 1'b1;
                    r_pos  <= r_pos + 1'b1;
                    if (walk_end) begin
                        r_dsel  <= D_AVG;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        unique case (r_dsel)
                            D_AVG: begin
                                r_avg <= div_q[RSSI_W-1:0];
                                if (trend_ok) begin
                                    r_dsel <= D_NEW;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            D_NEW: begin
                                r_new_avg <= div_q[RSSI_W-1:0];
                                r_dsel    <= D_OLD;
                            end
                            D_OLD: begin
                                r_old_avg <= div_q[RSSI_W-1:0];
                                r_state   <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_held   <= held_nx;
                        r_hold   <= hold_nx;
                        r_olevel <= level;
                        r_omove  <= move;
                        r_oavg   <= r_avg;
                        r_orose  <= r_rose;
                        r_orise  <= r_rise_time;
                        r_ocount <= r_fill;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_threat_level   = r_olevel;
    assign o_movement       = r_omove;
    assign o_average_rssi   = r_oavg;
    assign o_rose           = r_orose;
    assign o_last_rise_time = r_orise;
    assign o_valid_count    = r_ocount;

`ifndef SYNTHESIS
    a_walk_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (CW'(r_pos) < r_fill))
        else $error("history walk ran past the valid entries");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH)
        else $error("fill count above history depth");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == TR_UNKNOWN) |-> (r_hold == '0))
        else $error("hold counter running with no held trend");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV) && !r_dgo)
        else $error("divider finished outside the divide phase");
`endif

endmodule

`default_nettype wire

@@ rtl/rssi_threat_and_trend_tracker_unit.sv @@
`default_nettype none

// RSSI threat and trend tracker.
// Input channel: i_in_valid / o_in_stall carry one request (signed RSSI sample in
// dBm plus a 32-bit ms timestamp). A request is taken on a clock edge with valid
// high and stall low. The front stage decides the rise flag at once and parks the
// request in a two-entry queue; stall rises only when that queue is full.
// Output channel: o_out_valid / i_out_stall carry one result per request
// (threat level, held movement trend, truncated average, rise flag, last rise
// time, valid history count). The result sits in an output register until taken,
// and the back stage keeps working on the next queued request meanwhile.
// Per request: a queue pop, a walk over the valid history entries, one divide
// for the average and two more once the trend is evaluable, then a load into
// the output register. The back stage starts the next queued request only
// after that load, as the bit-serial divider is shared by all three divides.
// Configuration: plain write port, register i at index i; the user must write it
// only while idle, as the block itself does not enforce this.
// Reset (synchronous, active low) empties the queue, clears the history pointer,
// fill count, hysteresis and rise time, and loads register defaults.
module rssi_threat_and_trend_tracker_unit
    import rttt_pkg::*;
#(
    parameter int HISTORY_DEPTH     = DEF_HISTORY_DEPTH,
    parameter int MIN_TREND_HISTORY = DEF_MIN_TREND_HISTORY,
    parameter int HOLD_COUNT        = DEF_HOLD_COUNT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [IDX_W-1:0]                   i_cfg_idx,
    input  wire logic [RSSI_W-1:0]                  i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [RSSI_W-1:0]           i_rssi_sample,
    input  wire logic [TIME_W-1:0]                  i_sample_time,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [LVL_W-1:0]                        o_threat_level,
    output logic [MOVE_W-1:0]                       o_movement,
    output logic signed [RSSI_W-1:0]                o_average_rssi,
    output logic                                    o_rose,
    output logic [TIME_W-1:0]                       o_last_rise_time,
    output logic [$clog2(HISTORY_DEPTH + 1)-1:0]    o_valid_count
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    t_cfg  r_cfg;
    logic  push;
    t_qent push_ent;
    logic  q_full;
    logic  q_nonempty;
    logic  q_pop;
    t_qent q_ent;

    // configuration registers; all eight indexes are decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THREAT_LOW:      r_cfg.threat_low      <= i_cfg_data;
                REG_THREAT_MEDIUM:   r_cfg.threat_medium   <= i_cfg_data;
                REG_THREAT_HIGH:     r_cfg.threat_high     <= i_cfg_data;
                REG_THREAT_CRITICAL: r_cfg.threat_critical <= i_cfg_data;
                REG_APPROACH_MARGIN: r_cfg.approach_margin <= i_cfg_data;
                REG_RECEDE_MARGIN:   r_cfg.recede_margin   <= i_cfg_data;
                REG_SILENCE_LEVEL:   r_cfg.silence_level   <= i_cfg_data;
                REG_INITIAL_RSSI:    r_cfg.initial_rssi    <= i_cfg_data;
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    assign o_in_stall = q_full;

    // front: rise detection against the previous sample
    rttt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_in_valid),
        .i_rssi_sample (i_rssi_sample),
        .i_sample_time (i_sample_time),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_ent         (push_ent)
    );

    rttt_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_ent      (push_ent),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_ent      (q_ent)
    );

    // back: history ring, statistics, divides, hysteresis, output register
    rttt_back #(
        .HISTORY_DEPTH     (HISTORY_DEPTH),
        .MIN_TREND_HISTORY (MIN_TREND_HISTORY),
        .HOLD_COUNT        (HOLD_COUNT),
        .CW                (CW)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_nonempty     (q_nonempty),
        .i_q_ent          (q_ent),
        .o_q_pop          (q_pop),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_threat_level   (o_threat_level),
        .o_movement       (o_movement),
        .o_average_rssi   (o_average_rssi),
        .o_rose           (o_rose),
        .o_last_rise_time (o_last_rise_time),
        .o_valid_count    (o_valid_count)
    );

endmodule

`default_nettype wire

@@ dv/rssi_tracker_check.sv @@
// Watches the config port and both request channels, keeps its own copy of the
// tracker state, and compares every result against the oldest prediction.
module rssi_tracker_check
    import rttt_pkg::*;
(
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_cfg_we,
    input  wire logic [IDX_W-1:0]                           i_cfg_idx,
    input  wire logic [RSSI_W-1:0]                          i_cfg_data,
    input  wire logic                                       i_in_valid,
    input  wire logic                                       i_in_stall,
    input  wire logic signed [RSSI_W-1:0]                   i_rssi_sample,
    input  wire logic [TIME_W-1:0]                          i_sample_time,
    input  wire logic                                       i_out_valid,
    input  wire logic                                       i_out_stall,
    input  wire logic [LVL_W-1:0]                           i_threat_level,
    input  wire logic [MOVE_W-1:0]                          i_movement,
    input  wire logic signed [RSSI_W-1:0]                   i_average_rssi,
    input  wire logic                                       i_rose,
    input  wire logic [TIME_W-1:0]                          i_last_rise_time,
    input  wire logic [$clog2(DEF_HISTORY_DEPTH + 1)-1:0]   i_valid_count,
    output int                                              o_fail_count = 0,
    output int                                              o_pending = 0
);

    localparam int DEPTH = DEF_HISTORY_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [LVL_W-1:0]         level;
        t_trend                   move;
        logic signed [RSSI_W-1:0] avg;
        logic                     rose;
        logic [TIME_W-1:0]        rise_time;
        logic [CNT_W-1:0]         count;
    } t_report;

    t_report                  pending_reports [$];
    int                       setting [8];      // sign-extended register copies
    logic signed [RSSI_W-1:0] ring [DEPTH];
    int                       ring_ptr;
    int                       ring_fill;
    int                       last_dbm;
    int                       hold_run;
    int                       mismatches = 0;
    logic [TIME_W-1:0]        rise_stamp;
    t_trend                   held_trend;

    always @(posedge i_clk) begin : watch
        t_report got;
        t_report want;
        int      prior;
        int      peak;
        int      total;
        int      old_sum;
        int      new_sum;
        int      old_n;
        int      new_n;
        int      start;
        int      v;
        int      diff;
        t_trend  raw;
        if (!i_rst_n) begin
            pending_reports.delete();
            setting[REG_THREAT_LOW]      = int'($signed(CFG_RESET.threat_low));
            setting[REG_THREAT_MEDIUM]   = int'($signed(CFG_RESET.threat_medium));
            setting[REG_THREAT_HIGH]     = int'($signed(CFG_RESET.threat_high));
            setting[REG_THREAT_CRITICAL] = int'($signed(CFG_RESET.threat_critical));
            setting[REG_APPROACH_MARGIN] = int'($signed(CFG_RESET.approach_margin));
            setting[REG_RECEDE_MARGIN]   = int'($signed(CFG_RESET.recede_margin));
            setting[REG_SILENCE_LEVEL]   = int'($signed(CFG_RESET.silence_level));
            setting[REG_INITIAL_RSSI]    = int'($signed(CFG_RESET.initial_rssi));
            ring_ptr   = 0;
            ring_fill  = 0;
            last_dbm   = 0;
            hold_run   = 0;
            rise_stamp = '0;
            held_trend = TR_UNKNOWN;
            o_pending  = 0;
        end else begin
            if (i_cfg_we) begin
                setting[i_cfg_idx] = int'($signed(i_cfg_data));
            end

            // results first, so a request taken on this edge is never matched here
            if (i_out_valid && !i_out_stall) begin
                got = '{i_threat_level, t_trend'(i_movement), i_average_rssi, i_rose,
                        i_last_rise_time, i_valid_count};
                if (pending_reports.size() == 0) begin
                    o_fail_count++;
                    if (mismatches < 10) begin
                        $display("%0t: result with no request outstanding", $realtime);
                    end
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (mismatches < 10) begin
                            $display("%0t: mismatch exp lvl %0d mov %0d avg %0d rose %0d ",
                                     $realtime, want.level, want.move, $signed(want.avg),
                                     want.rose, "rt %0h cnt %0d", want.rise_time, want.count);
                            $display("%0t:          got lvl %0d mov %0d avg %0d rose %0d ",
                                     $realtime, got.level, got.move, $signed(got.avg),
                                     got.rose, "rt %0h cnt %0d", got.rise_time, got.count);
                        end
                        mismatches++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                prior = (ring_fill == 0) ? setting[REG_INITIAL_RSSI] : last_dbm;
                ring[ring_ptr] = i_rssi_sample;
                ring_ptr = (ring_ptr + 1) % DEPTH;
                if (ring_fill < DEPTH) begin
                    ring_fill++;
                end

                peak  = ring[0];
                total = 0;
                for (int i = 0; i < ring_fill; i++) begin
                    if (ring[i] > peak) begin
                        peak = ring[i];
                    end
                    total += ring[i];
                end
                if (peak >= setting[REG_THREAT_CRITICAL]) begin
                    want.level = LVL_CRITICAL;
                end else if (peak >= setting[REG_THREAT_HIGH]) begin
                    want.level = LVL_HIGH;
                end else if (peak >= setting[REG_THREAT_MEDIUM]) begin
                    want.level = LVL_MEDIUM;
                end else if (peak >= setting[REG_THREAT_LOW]) begin
                    want.level = LVL_LOW;
                end else begin
                    want.level = LVL_NONE;
                end

                want.rose = int'(i_rssi_sample) > prior;
                if (want.rose) begin
                    rise_stamp = i_sample_time;
                end
                last_dbm = i_rssi_sample;

                // raw trend: older half vs newer half, oldest first, silent skipped
                raw = TR_UNKNOWN;
                if (ring_fill >= DEF_MIN_TREND_HISTORY) begin
                    start   = (ring_fill >= DEPTH) ? ring_ptr : 0;
                    old_sum = 0;
                    new_sum = 0;
                    old_n   = 0;
                    new_n   = 0;
                    for (int i = 0; i < ring_fill; i++) begin
                        v = ring[(start + i) % DEPTH];
                        if (v > setting[REG_SILENCE_LEVEL]) begin
                            if (i < DEPTH / 2) begin
                                old_sum += v;
                                old_n++;
                            end else begin
                                new_sum += v;
                                new_n++;
                            end
                        end
                    end
                    if (old_n > 0 && new_n > 0) begin
                        diff = new_sum / new_n - old_sum / old_n;
                        if (diff > setting[REG_APPROACH_MARGIN]) begin
                            raw = TR_APPROACHING;
                        end else if (diff < setting[REG_RECEDE_MARGIN]) begin
                            raw = TR_RECEDING;
                        end else begin
                            raw = TR_STATIC;
                        end
                    end
                end

                // hysteresis on the held trend
                if (raw == held_trend) begin
                    hold_run = 0;
                end else if (raw == TR_UNKNOWN) begin
                    // keep held trend and run length
                end else if (held_trend == TR_UNKNOWN) begin
                    hold_run   = 0;
                    held_trend = raw;
                end else begin
                    hold_run++;
                    if (hold_run >= DEF_HOLD_COUNT) begin
                        hold_run   = 0;
                        held_trend = raw;
                    end
                end

                want.move      = held_trend;
                want.avg       = RSSI_W'(total / ring_fill);
                want.rise_time = rise_stamp;
                want.count     = CNT_W'(ring_fill);
                pending_reports.push_back(want);
            end
            o_pending = pending_reports.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// Top of the tracker bench: clock, reset, request stimulus, output-side stall
// and the verdict. All checking lives in the checker instance beside the DUT.
module testbench;
    import rttt_pkg::*;

    localparam int CNT_W       = $clog2(DEF_HISTORY_DEPTH + 1);
    localparam int PHASE_ITEMS = 140;
    localparam int PHASES      = 8;

    // Directed walk: first sample vs initial_rssi, field extremes, the
    // silence boundary, every threat threshold crossed upward, then a
    // plateau and a drop so the held trend has to fight the hysteresis.
    localparam int PROBE_DBM [24] = '{
        -5, 127, -128, -128, -111, -110, -109, -91,
        -90, -81, -80, -71, -70, -61, -60, -30,
        -30, -30, -100, -100, -100, -100, -100, -100
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [IDX_W-1:0]           i_cfg_idx;
    logic [RSSI_W-1:0]          i_cfg_data;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [RSSI_W-1:0]   i_rssi_sample;
    logic [TIME_W-1:0]          i_sample_time;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [LVL_W-1:0]           o_threat_level;
    logic [MOVE_W-1:0]          o_movement;
    logic signed [RSSI_W-1:0]   o_average_rssi;
    logic                       o_rose;
    logic [TIME_W-1:0]          o_last_rise_time;
    logic [CNT_W-1:0]           o_valid_count;

    int fail_count;
    int pending;
    bit calm = 1'b0;        // phase with no gaps and no stalls
    int stall_left = 0;

    rssi_threat_and_trend_tracker_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rssi_sample    (i_rssi_sample),
        .i_sample_time    (i_sample_time),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_threat_level   (o_threat_level),
        .o_movement       (o_movement),
        .o_average_rssi   (o_average_rssi),
        .o_rose           (o_rose),
        .o_last_rise_time (o_last_rise_time),
        .o_valid_count    (o_valid_count)
    );

    rssi_tracker_check watch (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_rssi_sample    (i_rssi_sample),
        .i_sample_time    (i_sample_time),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_threat_level   (o_threat_level),
        .i_movement       (o_movement),
        .i_average_rssi   (o_average_rssi),
        .i_rose           (o_rose),
        .i_last_rise_time (o_last_rise_time),
        .i_valid_count    (o_valid_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 8-unit clock period
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Output side: after each taken result, stall is held until a random countdown runs out.
    // Stall is also applied while no result is waiting, so it lands on
    // every phase of the back-end's work.
    always @(negedge i_clk) begin
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            stall_left <= calm ? 0 : $urandom_range(0, 3);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // One register write; we drops for a cycle so back-to-back calls never
    // lower and raise it in the same step.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= RSSI_W'(val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_registers(input int lo, input int med, input int hi, input int crit,
                                 input int app, input int rec, input int sil, input int init);
        write_reg(REG_THREAT_LOW, lo);
        write_reg(REG_THREAT_MEDIUM, med);
        write_reg(REG_THREAT_HIGH, hi);
        write_reg(REG_THREAT_CRITICAL, crit);
        write_reg(REG_APPROACH_MARGIN, app);
        write_reg(REG_RECEDE_MARGIN, rec);
        write_reg(REG_SILENCE_LEVEL, sil);
        write_reg(REG_INITIAL_RSSI, init);
    endtask

    // Present one request after a random gap and hold it until taken.
    // Returns at the falling edge after the accepting edge with valid still
    // high; the next call (or quiesce) decides what valid does next.
    task automatic send_request(input int dbm, input logic [TIME_W-1:0] stamp);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rssi_sample <= RSSI_W'(dbm);
        i_sample_time <= stamp;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every request has produced its result.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int                phase;
        int                k;
        int                left;
        int                slope;
        int                level;
        int                v;
        bit                noisy;
        logic [TIME_W-1:0] stamp;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_rssi_sample = '0;
        i_sample_time = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Before the first sample the rise test uses initial_rssi; set it
        // above the first probe so a stale default would show as a rise.
        write_reg(REG_INITIAL_RSSI, 0);
        for (k = 0; k < 24; k++) begin
            send_request(PROBE_DBM[k], (k == 1) ? '1 : TIME_W'(k * 7));
        end
        quiesce();

        stamp = 32'd100;
        left  = 0;
        slope = 0;
        level = 0;
        noisy = 1'b0;
        for (phase = 0; phase < PHASES; phase++) begin
            calm = (phase == 1 || phase == 5);
            unique case (phase)
                0: ;    // reset defaults
                1: set_registers(-128, -128, -128, -128, 127, -128, -128, -128);
                2: set_registers(127, 127, 127, 127, -128, 127, 127, 127);
                3: set_registers(-100, -85, -70, -55, 0, 0, -128, -60);
                default: set_registers($urandom_range(0, 255), $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 255),
                                       int'($urandom_range(0, 30)) - 15,
                                       int'($urandom_range(0, 30)) - 15,
                                       int'($urandom_range(0, 90)) - 128,
                                       $urandom_range(0, 255));
            endcase

            // Mostly ramps of random slope, start and length so the trend
            // logic sees real approach/recede/static runs; the rest is noise.
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (left == 0) begin
                    noisy = ($urandom_range(0, 9) < 3);
                    left  = noisy ? 1 : $urandom_range(4, 14);
                    slope = int'($urandom_range(0, 20)) - 10;
                    level = int'($urandom_range(0, 255)) - 128;
                end
                if (noisy) begin
                    v = int'($urandom_range(0, 255)) - 128;
                end else begin
                    v = level + int'($urandom_range(0, 4)) - 2;
                    level += slope;
                end
                if (v > 127) begin
                    v = 127;
                end else if (v < -128) begin
                    v = -128;
                end
                // timestamps mostly advance (and wrap), sometimes jump anywhere
                if ($urandom_range(0, 15) == 0) begin
                    stamp = $urandom;
                end else begin
                    stamp += $urandom_range(1, 3000);
                end
                send_request(v, stamp);
                left--;
            end
            quiesce();
        end

        // room for a stray late result to show up
        repeat (60) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
